/* rtl/assert_macros.svh */
// assertion macros used by the rtl back end (hsa_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: invariant");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");
`else
`define ASSERT_HOLDS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/hsa_pkg.sv */
// shared types, widths and register codes of the hysteresis step accumulator
package hsa_pkg;

	localparam int COUNT_BITS = 48;
	localparam int MOVE_W     = 32;
	localparam int RECIP_W    = 32;
	localparam int HYST_W     = 16;
	localparam int FRAC_W     = 17;
	localparam int BAND_OUT_W = 17;
	localparam int PROD_W     = MOVE_W + RECIP_W;
	localparam int DELTA_W    = PROD_W - 16;
	localparam int SUM_W      = DELTA_W + 1;
	localparam int WHOLE_W    = SUM_W - 16 + 1;
	localparam int BAND_W     = WHOLE_W + 1;
	localparam int SAT_W      = ((COUNT_BITS > BAND_W) ? COUNT_BITS : BAND_W) + 1;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_RECIPROCAL  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_STEPS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_POSITIVE   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_NEGATIVE   = 8'd3;

	localparam logic [RECIP_W-1:0] RECIP_RESET = 32'h0001_0000;

	typedef logic signed [MOVE_W-1:0]     movement_t;
	typedef logic signed [COUNT_BITS-1:0] count_t;
	typedef logic signed [FRAC_W-1:0]     fraction_t;
	typedef logic signed [BAND_OUT_W-1:0] band_t;
	typedef logic signed [DELTA_W-1:0]    delta_t;
	typedef logic signed [WHOLE_W-1:0]    whole_t;
	typedef logic signed [BAND_W-1:0]     band_wide_t;

	typedef struct packed {
		logic [RECIP_W-1:0] step_reciprocal;
		logic [HYST_W-1:0]  hysteresis_steps;
		logic               allow_positive;
		logic               allow_negative;
	} cfg_t;

	localparam count_t CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam count_t CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

endpackage

/* rtl/hsa_if.sv */
// valid/ready channel interfaces for movement beats and result beats
interface hsa_in_if import hsa_pkg::*; ();
	logic      valid;
	logic      ready;
	movement_t movement;

	modport source(output valid, output movement, input ready);
	modport sink(input valid, input movement, output ready);
endinterface

interface hsa_out_if import hsa_pkg::*; ();
	logic      valid;
	logic      ready;
	count_t    step_count;
	fraction_t step_fraction;
	band_t     dead_band;

	modport source(output valid, output step_count, output step_fraction, output dead_band,
		input ready);
	modport sink(input valid, input step_count, input step_fraction, input dead_band,
		output ready);
endinterface

/* rtl/hsa_front.sv */
// front end: takes movement beats and scales them into signed step deltas
module hsa_front import hsa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	hsa_in_if.sink              in_ch,
	input  logic [RECIP_W-1:0]  step_reciprocal,
	output logic                push_valid,
	output delta_t              push_data,
	input  logic                push_ready
);

	logic                neg;
	logic [MOVE_W-1:0]   mag;
	logic [PROD_W-1:0]   prod;
	logic                accept;
	logic                valid_s1;
	logic                neg_s1;
	logic [PROD_W-1:0]   prod_s1;
	delta_t              scaled;

	// magnitude of the movement and its product with the reciprocal
	always_comb begin
		neg  = in_ch.movement[MOVE_W-1];
		mag  = neg ? MOVE_W'(-in_ch.movement) : MOVE_W'(in_ch.movement);
		prod = PROD_W'(mag) * PROD_W'(step_reciprocal);
	end

	assign in_ch.ready = !valid_s1 || push_ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// product stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !push_ready);
		end
	end

	// product stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_s1  <= neg;
			prod_s1 <= prod;
		end
	end

	// drop the low fraction bits and restore the sign
	always_comb begin
		scaled    = delta_t'(prod_s1[PROD_W-1:16]);
		push_data = neg_s1 ? -scaled : scaled;
	end

	assign push_valid = valid_s1;

endmodule

/* rtl/hsa_queue.sv */
// two-entry delta queue between the front end and the accumulator back end
module hsa_queue import hsa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	input  delta_t  push_data,
	output logic    push_ready,
	output logic    pop_valid,
	output delta_t  pop_data,
	input  logic    pop
);

	delta_t      mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        push;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && pop_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop && pop_valid);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/hsa_back.sv */
// back end: fraction split, dead-band clamp and saturating step count
`include "assert_macros.svh"
module hsa_back import hsa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  delta_t  q_data,
	output logic    q_pop,
	hsa_out_if.source out_ch
);

	logic            en;
	logic            load_s1;
	logic            load_s2;
	logic            load_s3;

	fraction_t       frac_q;
	band_t           band_q;
	count_t          count_q;

	logic            valid_s1;
	whole_t          whole_s1;
	fraction_t       frac_s1;

	logic            valid_s2;
	band_wide_t      diff_s2;
	logic            commit_s2;
	fraction_t       frac_s2;
	band_t           band_s2;

	logic            valid_s3;
	fraction_t       frac_s3;
	band_t           band_s3;

	logic signed [SUM_W-1:0] sum;
	logic            round_up;
	whole_t          whole_d;
	fraction_t       frac_d;

	band_wide_t      band_sum;
	band_wide_t      hyst_w;
	band_wide_t      diff_d;
	logic            commit_d;
	band_t           band_d;
	band_t           hyst_n;

	logic signed [SAT_W-1:0] total;
	count_t          count_d;

	// whole pipeline moves when the result register is free or taken
	assign en      = !valid_s3 || out_ch.ready;
	assign q_pop   = en;
	assign load_s1 = en && q_valid;
	assign load_s2 = en && valid_s1;
	assign load_s3 = en && valid_s2;

	// fraction split, whole steps truncated toward zero
	always_comb begin
		sum      = SUM_W'(frac_q) + SUM_W'(q_data);
		round_up = sum[SUM_W-1] && (sum[15:0] != 16'd0);
		whole_d  = whole_t'($signed(sum[SUM_W-1:16])) + whole_t'(round_up);
		frac_d   = {round_up, sum[15:0]};
	end

	// dead-band clamp and the excess to commit
	always_comb begin
		band_sum = BAND_W'(band_q) + BAND_W'(whole_s1);
		hyst_w   = BAND_W'(cfg.hysteresis_steps);
		diff_d   = '0;
		commit_d = 1'b0;
		band_d   = band_sum[BAND_OUT_W-1:0];
		if (band_sum > hyst_w) begin
			diff_d   = band_sum - hyst_w;
			commit_d = cfg.allow_positive;
			band_d   = band_t'(hyst_w[BAND_OUT_W-1:0]);
		end else if (band_sum < -hyst_w) begin
			diff_d   = band_sum + hyst_w;
			commit_d = cfg.allow_negative;
			band_d   = band_t'(-hyst_w[BAND_OUT_W-1:0]);
		end
	end

	// saturating count update
	always_comb begin
		total   = SAT_W'(count_q) + SAT_W'(diff_s2);
		count_d = count_q;
		if (commit_s2) begin
			if (total > SAT_W'(CNT_MAX)) begin
				count_d = CNT_MAX;
			end else if (total < SAT_W'(CNT_MIN)) begin
				count_d = CNT_MIN;
			end else begin
				count_d = total[COUNT_BITS-1:0];
			end
		end
	end

	// accumulators and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q   <= '0;
			band_q   <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (load_s1) begin
				frac_q <= frac_d;
			end
			if (load_s2) begin
				band_q <= band_d;
			end
			if (load_s3) begin
				count_q <= count_d;
			end
			if (en) begin
				valid_s1 <= q_valid;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (load_s1) begin
			whole_s1 <= whole_d;
			frac_s1  <= frac_d;
		end
		if (load_s2) begin
			diff_s2   <= diff_d;
			commit_s2 <= commit_d;
			frac_s2   <= frac_s1;
			band_s2   <= band_d;
		end
		if (load_s3) begin
			frac_s3 <= frac_s2;
			band_s3 <= band_s2;
		end
	end

	assign out_ch.valid         = valid_s3;
	assign out_ch.step_count    = count_q;
	assign out_ch.step_fraction = frac_s3;
	assign out_ch.dead_band     = band_s3;

	assign hyst_n = band_t'(cfg.hysteresis_steps);

	// fraction never reaches a full step
	`ASSERT_HOLDS(a_frac_range, clk, arst_n, frac_q != {1'b1, 16'd0})
	// band lands inside the hysteresis that was in force
	`ASSERT_NEXT(a_band_clamped, clk, arst_n, load_s2,
		(band_q <= $past(hyst_n)) && (band_q >= -$past(hyst_n)))
	// a stalled result keeps its count
	`ASSERT_NEXT(a_count_held, clk, arst_n, valid_s3 && !out_ch.ready, $stable(count_q))

endmodule

/* rtl/hysteresis_step_accumulator_core.sv */
// top level: configuration registers, front end, delta queue and back end
// path: a taken beat passes the front-end product stage, a queue entry and back-end s1, s2 and s3
// throughput: one beat per cycle unless out_ch stalls; the 32x32 scaling multiply sits in its own stage
// the fraction, band and count recurrences each close through their own register in the back end
// reset: arst_n clears accumulators, pipeline valids and queue; registers take defaults
module hysteresis_step_accumulator_core import hsa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	hsa_in_if.sink                 in_ch,
	hsa_out_if.source              out_ch
);

	cfg_t    cfg_q;
	logic    push_valid;
	delta_t  push_data;
	logic    push_ready;
	logic    q_valid;
	delta_t  q_data;
	logic    q_pop;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_reciprocal  <= RECIP_RESET;
			cfg_q.hysteresis_steps <= '0;
			cfg_q.allow_positive   <= 1'b1;
			cfg_q.allow_negative   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_RECIPROCAL: begin
					cfg_q.step_reciprocal <= cfg_data[RECIP_W-1:0];
				end
				REG_HYSTERESIS_STEPS: begin
					cfg_q.hysteresis_steps <= cfg_data[HYST_W-1:0];
				end
				REG_ALLOW_POSITIVE: begin
					cfg_q.allow_positive <= cfg_data[0];
				end
				REG_ALLOW_NEGATIVE: begin
					cfg_q.allow_negative <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	hsa_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.step_reciprocal (cfg_q.step_reciprocal),
		.push_valid      (push_valid),
		.push_data       (push_data),
		.push_ready      (push_ready)
	);

	hsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_data   (q_data),
		.pop        (q_pop)
	);

	hsa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

/* verif/hsa_position_check.sv */
// checker: predicts each result beat from the movement beats and compares the outputs
module hsa_position_check import hsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hsa_in_if                     in_mon,
	hsa_out_if                    out_mon,
	output int                    fail_count,
	output int                    pending,
	output int                    beats_compared,
	output int                    saturations
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		count_t    step_count;
		fraction_t step_fraction;
		band_t     dead_band;
	} position_t;

	position_t results_due[$];

	// shadow of the registers and of the three accumulators
	cfg_t      shadow;
	fraction_t frac_q;
	band_t     band_q;
	count_t    count_q;

	// saturating add of committed steps into the count
	function automatic void commit_steps(longint steps);
		longint total;
		total = longint'(count_q);
		if (steps > 0 && total > longint'(CNT_MAX) - steps) begin
			total = longint'(CNT_MAX);
			saturations++;
		end else if (steps < 0 && total < longint'(CNT_MIN) - steps) begin
			total = longint'(CNT_MIN);
			saturations++;
		end else begin
			total = total + steps;
		end
		count_q = count_t'(total);
	endfunction

	// one movement beat: scale, split off whole steps, clamp the band, commit overflow
	function automatic position_t track_movement(movement_t move);
		logic [32:0] mag;
		logic [63:0] prod;
		longint      delta;
		longint      sum;
		longint      whole;
		longint      band;
		longint      hyst;
		mag = move[MOVE_W-1] ? (33'h1_0000_0000 - {1'b0, move}) : {1'b0, move};
		prod = 64'(mag) * 64'(shadow.step_reciprocal);
		delta = longint'(prod >> 16);
		if (move[MOVE_W-1])
			delta = -delta;
		sum = longint'(frac_q) + delta;
		// signed division truncates toward zero, so the fraction keeps the sign of the sum
		whole = sum / 65536;
		frac_q = fraction_t'(sum - whole * 65536);
		band = longint'(band_q) + whole;
		hyst = longint'(shadow.hysteresis_steps);
		if (band > hyst) begin
			if (shadow.allow_positive)
				commit_steps(band - hyst);
			band = hyst;
		end
		if (band < -hyst) begin
			if (shadow.allow_negative)
				commit_steps(band + hyst);
			band = -hyst;
		end
		band_q = band_t'(band);
		return position_t'{count_q, frac_q, band_q};
	endfunction

	// register snoop, result compare, then prediction of newly taken beats
	always @(posedge clk or negedge arst_n) begin
		position_t got;
		position_t want;
		bit        bad;
		if (!arst_n) begin
			results_due.delete();
			shadow = '{RECIP_RESET, 16'd0, 1'b1, 1'b1};
			frac_q = '0;
			band_q = '0;
			count_q = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP_RECIPROCAL: shadow.step_reciprocal = cfg_data[RECIP_W-1:0];
					REG_HYSTERESIS_STEPS: shadow.hysteresis_steps = cfg_data[HYST_W-1:0];
					REG_ALLOW_POSITIVE: shadow.allow_positive = cfg_data[0];
					REG_ALLOW_NEGATIVE: shadow.allow_negative = cfg_data[0];
					default: ;
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				got = position_t'{out_mon.step_count, out_mon.step_fraction, out_mon.dead_band};
				beats_compared++;
				if (results_due.size() == 0) begin
					if (fail_count < 20)
						$display("%0t unexpected result beat: expected none, got count %0d fraction %0d band %0d",
							$time, got.step_count, got.step_fraction, got.dead_band);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					bad = 1'b0;
					if (got.step_count !== want.step_count) begin
						bad = 1'b1;
						if (fail_count < 20)
							$display("%0t step_count mismatch: expected %0d got %0d",
								$time, want.step_count, got.step_count);
					end
					if (got.step_fraction !== want.step_fraction) begin
						bad = 1'b1;
						if (fail_count < 20)
							$display("%0t step_fraction mismatch: expected %0d got %0d",
								$time, want.step_fraction, got.step_fraction);
					end
					if (got.dead_band !== want.dead_band) begin
						bad = 1'b1;
						if (fail_count < 20)
							$display("%0t dead_band mismatch: expected %0d got %0d",
								$time, want.dead_band, got.dead_band);
					end
					if (bad)
						fail_count++;
				end
			end
			if (in_mon.valid && in_mon.ready)
				results_due.push_back(track_movement(in_mon.movement));
		end
		pending = results_due.size();
	end

endmodule

/* verif/tb_hysteresis_step_accumulator_core.sv */
// testbench top: clock, reset, register writes, movement stimulus, receiver and verdict
module tb_hysteresis_step_accumulator_core;
	timeunit 1ns;
	timeprecision 1ps;
	import hsa_pkg::*;

	// indexes past the register list, which the block must ignore
	localparam logic [CFG_IDX_W-1:0] REG_PAST_LIST  = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = 8'hFF;
	localparam int RESULT_LATENCY = 8;
	localparam int CHOKE_CYCLES   = 400;
	localparam int PHASES         = 10;
	localparam int PHASE_BEATS    = 70;
	localparam int CHOKE_BEATS    = 40;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hsa_in_if  in_ch();
	hsa_out_if out_ch();

	int fail_count;
	int pending;
	int beats_compared;
	int saturations;
	int send_gap_pct;
	int recv_stall_pct;
	bit choke_req;
	int beats_sent;
	int settings_used;

	hysteresis_step_accumulator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	hsa_position_check position_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_mon         (in_ch),
		.out_mon        (out_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.beats_compared (beats_compared),
		.saturations    (saturations)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// result receiver: random stalls, plus one long choke when requested
	initial begin : receiver
		int choked;
		choked = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (choke_req && choked < CHOKE_CYCLES) begin
				out_ch.ready <= 1'b0;
				choked++;
			end else begin
				if (!choke_req)
					choked = 0;
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// offer one movement beat, with random gaps ahead of it
	task automatic send_beat(movement_t move);
		while ($urandom_range(99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.movement <= move;
		do @(posedge clk); while (!in_ch.ready);
		beats_sent++;
	endtask

	task automatic stop_sending();
		in_ch.valid <= 1'b0;
	endtask

	// wait for every predicted result, then let the pipeline settle
	task automatic drain();
		@(posedge clk);
		wait (pending == 0);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(logic [31:0] recip, logic [15:0] hyst, bit pos, bit neg);
		stop_sending();
		drain();
		write_reg(REG_STEP_RECIPROCAL, recip);
		write_reg(REG_HYSTERESIS_STEPS, {16'd0, hyst});
		write_reg(REG_ALLOW_POSITIVE, {31'd0, pos});
		write_reg(REG_ALLOW_NEGATIVE, {31'd0, neg});
		end_writes();
		settings_used++;
	endtask

	initial begin : stimulus
		movement_t   move;
		logic [31:0] recip;
		logic [15:0] hyst;
		bit          pos;
		bit          neg;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.movement = '0;
		arst_n = 1'b0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		choke_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: fractions, sign changes and the movement extremes
		send_beat(32'sh0000_0000);
		send_beat(32'sh0000_8000);
		send_beat(32'sh0000_8000);
		send_beat(32'shFFFF_4000);
		send_beat(32'sh7FFF_FFFF);
		send_beat(32'sh8000_0000);
		send_beat(32'shFFFF_FFFF);
		send_beat(32'sh0000_0001);

		// band of three: positive overflow dropped, negative overflow committed
		apply_settings(RECIP_RESET, 16'd3, 1'b0, 1'b1);
		send_beat(32'sh0005_0000);
		send_beat(32'shFFF6_0000);
		send_beat(32'sh0000_0000);

		// band lowered to one while holding minus three
		apply_settings(RECIP_RESET, 16'd1, 1'b0, 1'b1);
		send_beat(32'sh0000_0000);

		// negative commits disabled, positive enabled
		apply_settings(RECIP_RESET, 16'd2, 1'b1, 1'b0);
		send_beat(32'shFFFB_0000);
		send_beat(32'sh0005_0000);

		// largest reciprocal gives the largest step deltas, moving the count up and then down
		apply_settings(32'hFFFF_FFFF, 16'd0, 1'b1, 1'b1);
		repeat (3) send_beat(32'sh7FFF_FFFF);
		repeat (4) send_beat(32'sh8000_0000);

		// zero reciprocal scales everything to nothing
		apply_settings(32'd0, 16'hFFFF, 1'b1, 1'b1);
		send_beat(32'sh7FFF_FFFF);
		send_beat(32'sh8000_0000);

		// writes past the register list change nothing
		apply_settings(RECIP_RESET, 16'd0, 1'b1, 1'b1);
		write_reg(REG_PAST_LIST, 32'd0);
		write_reg(REG_LAST_INDEX, 32'hFFFF_FFFF);
		end_writes();
		send_beat(32'sh0001_0000);

		// random phases, cycling through the idle patterns
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					recip = RECIP_RESET;
					hyst = 16'd0;
					pos = 1'b1;
					neg = 1'b1;
				end
				1: begin
					recip = 32'hFFFF_FFFF;
					hyst = 16'hFFFF;
					pos = 1'b1;
					neg = 1'b1;
				end
				2: begin
					recip = 32'd1;
					hyst = 16'd0;
					pos = 1'b0;
					neg = 1'b1;
				end
				default: begin
					recip = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 32'h0010_0000);
					case ($urandom_range(3))
						0: hyst = 16'd0;
						1: hyst = 16'hFFFF;
						2: hyst = 16'($urandom_range(12));
						default: hyst = 16'($urandom);
					endcase
					pos = 1'($urandom_range(1));
					neg = 1'($urandom_range(1));
				end
			endcase
			apply_settings(recip, hyst, pos, neg);
			case (phase % 4)
				0: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct = 48;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 48;
				end
				default: begin
					send_gap_pct = 38;
					recv_stall_pct = 38;
				end
			endcase
			for (int k = 0; k < PHASE_BEATS; k++) begin
				// mid-phase pause until every result is back
				if (k == PHASE_BEATS / 2) begin
					stop_sending();
					drain();
				end
				case ($urandom_range(9))
					0: move = $urandom;
					1: begin
						case ($urandom_range(3))
							0: move = 32'sh7FFF_FFFF;
							1: move = 32'sh8000_0000;
							2: move = 32'shFFFF_FFFF;
							default: move = 32'sh0000_0000;
						endcase
					end
					default: move = movement_t'(int'($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000);
				endcase
				send_beat(move);
			end
		end

		// long receiver choke while the sender keeps offering beats
		apply_settings(32'h0002_8000, 16'd4, 1'b1, 1'b1);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		choke_req = 1'b1;
		for (int k = 0; k < CHOKE_BEATS; k++)
			send_beat(movement_t'(int'($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000));
		stop_sending();
		drain();
		choke_req = 1'b0;

		$display("%0d movement beats sent, %0d result beats compared over %0d register settings",
			beats_sent, beats_compared, settings_used);
		$display("count hit a saturation limit %0d times; receiver choked for %0d cycles once",
			saturations, CHOKE_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
